// File: rtl/mccl_pkg.sv
package mccl_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int MIDI_W = 7;
  localparam int CHAN_W = 5;
  localparam int KNOB_W = MIDI_W + FRACTION_BITS;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [MIDI_W-1:0] MIDI_MAX = MIDI_W'(127);
  localparam logic [KNOB_W-1:0] KNOB_MAX = KNOB_W'(MIDI_MAX) << FRACTION_BITS;

  localparam int IN_BITS = MIDI_W + MIDI_W + CHAN_W + KNOB_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = KNOB_W + 1 + 2 + MIDI_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_FILTER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_CONTROL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PICKUP_ENABLE = 2'd2;

  localparam logic [1:0] MODE_CODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CODE_LEARN = 2'd1;
  localparam logic [1:0] MODE_CODE_PICKUP = 2'd2;

  typedef enum logic [1:0] {
    ACT_CC    = 2'd0,
    ACT_LEARN = 2'd1,
    ACT_SET   = 2'd2,
    ACT_ARM   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_LEARN  = 3'b010,
    MODE_PICKUP = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    DIR_START = 2'd0,
    DIR_LESS  = 2'd1,
    DIR_MORE  = 2'd2,
    DIR_DONE  = 2'd3
  } dir_t;

  typedef struct packed {
    action_t             action;
    logic [MIDI_W-1:0]   control_number;
    logic [MIDI_W-1:0]   control_value;
    logic [CHAN_W-1:0]   event_channel;
    logic [KNOB_W-1:0]   new_position;
  } item_t;

  typedef struct packed {
    mode_t               mode;
    dir_t                dir;
    logic [KNOB_W-1:0]   knob;
    logic [MIDI_W-1:0]   bound;
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel_filter;
    logic                pickup_enable;
  } cfg_t;

  typedef struct packed {
    logic [KNOB_W-1:0]   knob_position;
    logic                value_changed;
    logic [1:0]          current_mode;
    logic [MIDI_W-1:0]   current_control;
  } result_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_LEARN:  c = MODE_CODE_LEARN;
      MODE_PICKUP: c = MODE_CODE_PICKUP;
      default:     c = MODE_CODE_NORMAL;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mccl_in_stage.sv
module mccl_in_stage import mccl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // control_number, control_value, event_channel, new_position, zero pad
  input  logic [IN_DATA_W-1:0] s_tdata,
  // action
  input  logic [1:0]           s_tuser,
  input  logic                 advance,
  output logic                 valid,
  output item_t                item
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action         <= action_t'(s_tuser);
      item.control_number <= s_tdata[MIDI_W-1:0];
      item.control_value  <= s_tdata[2*MIDI_W-1:MIDI_W];
      item.event_channel  <= s_tdata[2*MIDI_W+CHAN_W-1:2*MIDI_W];
      item.new_position   <= s_tdata[IN_BITS-1:2*MIDI_W+CHAN_W];
    end
  end

endmodule

// File: rtl/mccl_core.sv
module mccl_core import mccl_pkg::*; (
  input  item_t   item,
  input  state_t  state,
  input  cfg_t    cfg,
  output state_t  state_next,
  output result_t result
);

  logic [KNOB_W-1:0] w;
  mode_t             m1;
  dir_t              d1;
  logic [MIDI_W-1:0] b1;
  logic              match;
  dir_t              side;
  logic              changed;

  assign w = KNOB_W'(item.control_value) << FRACTION_BITS;
  assign side = (w < state.knob) ? DIR_LESS : DIR_MORE;

  // learn pass binds the controller before the event is handled again
  always_comb begin
    m1 = state.mode;
    d1 = state.dir;
    b1 = state.bound;
    if (state.mode == MODE_LEARN) begin
      b1 = item.control_number;
      if (cfg.pickup_enable) begin
        m1 = MODE_PICKUP;
        d1 = DIR_START;
      end else begin
        m1 = MODE_NORMAL;
        d1 = DIR_DONE;
      end
    end
  end

  assign match = (b1 != '0) && (item.control_number == b1) &&
                 ((cfg.channel_filter == '0) || (item.event_channel == cfg.channel_filter));

  always_comb begin
    state_next = state;
    changed = 1'b0;
    case (item.action)
      ACT_CC: begin
        state_next.mode = m1;
        state_next.dir = d1;
        state_next.bound = b1;
        if (m1 == MODE_PICKUP) begin
          if (match) begin
            if (w == state.knob || (d1 != DIR_START && d1 != side)) begin
              state_next.mode = MODE_NORMAL;
              state_next.dir = DIR_DONE;
              state_next.knob = w;
              changed = 1'b1;
            end else if (d1 == DIR_START) begin
              state_next.dir = side;
            end
          end
        end else if (match) begin
          state_next.knob = w;
          changed = 1'b1;
        end
      end
      ACT_LEARN: begin
        if (state.mode == MODE_LEARN) begin
          state_next.mode = MODE_NORMAL;
          state_next.dir = DIR_DONE;
        end else begin
          state_next.mode = MODE_LEARN;
        end
      end
      ACT_SET: begin
        state_next.knob = (item.new_position > KNOB_MAX) ? KNOB_MAX : item.new_position;
        changed = 1'b1;
      end
      ACT_ARM: begin
        if (state.bound != '0 && cfg.pickup_enable) begin
          state_next.mode = MODE_PICKUP;
          state_next.dir = DIR_START;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  assign result.knob_position = state_next.knob;
  assign result.value_changed = changed;
  assign result.current_mode = mode_code(state_next.mode);
  assign result.current_control = state_next.bound;

endmodule

// File: rtl/mccl_out_stage.sv
module mccl_out_stage import mccl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  result_t               result,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // knob_position, value_changed, current_mode, current_control, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      m_tdata <= OUT_DATA_W'({result.current_control, result.current_mode,
                              result.value_changed, result.knob_position});
    end
  end

endmodule

// File: rtl/midi_cc_learn_pickup_unit.sv
// MIDI control-change learn and soft takeover for one fader.
// Input stream: s_tuser carries the action (CC event, learn toggle, set knob,
// arm pickup); s_tdata carries controller number, value, channel and the new
// knob position. Every accepted item gives exactly one result on the output
// stream: knob position (MIDI value times 256), value_changed flag, mode code
// and bound controller number.
// Configuration: cfg_we writes cfg_data into register cfg_addr at the clock
// edge (0 channel filter, 1 initial control, 2 pickup enable); write only
// while no item is in flight.
// Path: an accepted item waits in the input register, then passes through the
// decision logic into the output register, which drives m_tvalid and m_tdata.
// Throughput is one item per cycle while the receiver takes results; state is
// read and updated as an item moves between the two registers, so consecutive
// items chain directly.
// When the receiver stalls the output register holds its result and the
// input register holds one more item; s_tready drops once both are full.
// Reset (rst, synchronous) empties both registers, sets mode normal, knob 0,
// no bound controller, channel filter 0 and pickup enabled.
module midi_cc_learn_pickup_unit import mccl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // control_number, control_value, event_channel, new_position, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // knob_position, value_changed, current_mode, current_control, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    in_valid;
  item_t   item;
  logic    out_free;
  logic    advance;
  state_t  state;
  state_t  state_next;
  cfg_t    cfg;
  result_t result;

  assign advance = in_valid && out_free;

  mccl_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .valid    (in_valid),
    .item     (item)
  );

  mccl_core u_core (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  mccl_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_filter <= '0;
      cfg.pickup_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CHANNEL_FILTER: cfg.channel_filter <= cfg_data[CHAN_W-1:0];
        CFG_PICKUP_ENABLE:  cfg.pickup_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= MODE_NORMAL;
      state.dir <= DIR_START;
      state.knob <= '0;
      state.bound <= '0;
    end else if (advance) begin
      state <= state_next;
    end else if (cfg_we && cfg_addr == CFG_INITIAL_CONTROL) begin
      state.bound <= cfg_data[MIDI_W-1:0];
    end
  end

  a_knob_range: assert property (@(posedge clk) disable iff (rst)
    state.knob <= KNOB_MAX)
    else $error("knob above full scale");

  a_pickup_dir: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_PICKUP |-> state.dir != DIR_DONE)
    else $error("pickup with finished direction");

  a_learn_leaves: assert property (@(posedge clk) disable iff (rst)
    (advance && item.action == ACT_CC && state.mode == MODE_LEARN)
    |=> state.mode != MODE_LEARN)
    else $error("CC event left block in learn");

endmodule

// File: sim/midi_cc_learn_pickup_checker.sv
module midi_cc_learn_pickup_checker import mccl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // control_number, control_value, event_channel, new_position, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // knob_position, value_changed, current_mode, current_control, zero pad
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic [CHAN_W-1:0] chan_sel;
  logic              pickup_on;
  logic [1:0]        fader_mode;
  dir_t              takeover_dir;
  logic [KNOB_W-1:0] knob;
  logic [MIDI_W-1:0] bound_cc;
  result_t           fader_results[$];
  int                fail_count = 0;
  int                waiting = 0;

  assign errors = fail_count;
  assign pending = waiting;

  function automatic logic cc_hit(logic [MIDI_W-1:0] num, logic [CHAN_W-1:0] ch);
    return (bound_cc != '0) && (num == bound_cc) && (chan_sel == '0 || ch == chan_sel);
  endfunction

  task automatic release_takeover();
    fader_mode = MODE_CODE_NORMAL;
    takeover_dir = DIR_DONE;
  endtask

  task automatic apply_cc(input logic [MIDI_W-1:0] num, input logic [MIDI_W-1:0] val,
                          input logic [CHAN_W-1:0] ch, output logic moved);
    logic [KNOB_W-1:0] target;
    dir_t              side;
    logic              settled;
    target = KNOB_W'(val) << FRACTION_BITS;
    moved = 1'b0;
    settled = 1'b0;
    // learn, then pickup, then normal: at most three passes
    for (int pass = 0; pass < 3; pass++) begin
      if (!settled) begin
        if (fader_mode == MODE_CODE_LEARN) begin
          bound_cc = num;
          if (pickup_on) begin
            fader_mode = MODE_CODE_PICKUP;
            takeover_dir = DIR_START;
          end else begin
            release_takeover();
          end
        end else if (fader_mode == MODE_CODE_PICKUP) begin
          if (!cc_hit(num, ch)) begin
            settled = 1'b1;
          end else if (target == knob) begin
            release_takeover();
          end else begin
            side = (target < knob) ? DIR_LESS : DIR_MORE;
            if (takeover_dir == DIR_START) begin
              takeover_dir = side;
              settled = 1'b1;
            end else if (takeover_dir == DIR_DONE || takeover_dir != side) begin
              release_takeover();
            end else begin
              settled = 1'b1;
            end
          end
        end else begin
          if (cc_hit(num, ch)) begin
            knob = target;
            moved = 1'b1;
          end
          settled = 1'b1;
        end
      end
    end
  endtask

  task automatic predict_item(input action_t act, input logic [IN_DATA_W-1:0] data);
    logic [MIDI_W-1:0] num;
    logic [MIDI_W-1:0] val;
    logic [CHAN_W-1:0] ch;
    logic [KNOB_W-1:0] pos;
    logic              moved;
    result_t           r;
    num = data[MIDI_W-1:0];
    val = data[2*MIDI_W-1:MIDI_W];
    ch = data[2*MIDI_W +: CHAN_W];
    pos = data[2*MIDI_W+CHAN_W +: KNOB_W];
    moved = 1'b0;
    case (act)
      ACT_CC: begin
        apply_cc(num, val, ch, moved);
      end
      ACT_LEARN: begin
        if (fader_mode == MODE_CODE_LEARN) release_takeover();
        else fader_mode = MODE_CODE_LEARN;
      end
      ACT_SET: begin
        knob = (pos > KNOB_MAX) ? KNOB_MAX : pos;
        moved = 1'b1;
      end
      default: begin
        if (bound_cc != '0 && pickup_on) begin
          fader_mode = MODE_CODE_PICKUP;
          takeover_dir = DIR_START;
        end
      end
    endcase
    r.knob_position = knob;
    r.value_changed = moved;
    r.current_mode = fader_mode;
    r.current_control = bound_cc;
    fader_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      chan_sel = '0;
      pickup_on = 1'b1;
      fader_mode = MODE_CODE_NORMAL;
      takeover_dir = DIR_START;
      knob = '0;
      bound_cc = '0;
      fader_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (fader_results.size() == 0) begin
          $display("%0t: unexpected result expected none got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = fader_results.pop_front();
          check_field("knob_position", want.knob_position, m_tdata[KNOB_W-1:0]);
          check_field("value_changed", want.value_changed, m_tdata[KNOB_W]);
          check_field("current_mode", want.current_mode, m_tdata[KNOB_W+1 +: 2]);
          check_field("current_control", want.current_control, m_tdata[KNOB_W+3 +: MIDI_W]);
          check_field("pad", 0, m_tdata[OUT_DATA_W-1:OUT_BITS]);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CHANNEL_FILTER:  chan_sel = cfg_data[CHAN_W-1:0];
          CFG_INITIAL_CONTROL: bound_cc = cfg_data[MIDI_W-1:0];
          CFG_PICKUP_ENABLE:   pickup_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_item(action_t'(s_tuser), s_tdata);
    end
    waiting = fader_results.size();
  end

endmodule

// File: sim/tb_midi_cc_learn_pickup_unit.sv
module tb_midi_cc_learn_pickup_unit;
  import mccl_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 48;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 155;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = ACT_CC;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  midi_cc_learn_pickup_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  midi_cc_learn_pickup_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("midi_cc_learn_pickup_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pattern;
    int left;
    int hold;
    int tick;
    pattern = 0;
    left = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready = 1'b0;
      end else begin
        if (left == 0) begin
          pattern = $urandom_range(0, 3);
          left = $urandom_range(16, 80);
        end
        left--;
        case (pattern)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 3) == 0);
          default: m_tready = (tick % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_item(input action_t act, input logic [MIDI_W-1:0] num,
                           input logic [MIDI_W-1:0] val, input logic [CHAN_W-1:0] ch,
                           input logic [KNOB_W-1:0] pos);
    int gap;
    s_tuser = act;
    s_tdata = IN_DATA_W'({pos, ch, val, num});
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CHAN_W-1:0] filter, input logic [MIDI_W-1:0] ctrl,
                           input logic enable);
    write_reg(CFG_CHANNEL_FILTER, CFG_DATA_W'(filter));
    write_reg(CFG_INITIAL_CONTROL, CFG_DATA_W'(ctrl));
    write_reg(CFG_PICKUP_ENABLE, CFG_DATA_W'(enable));
    cfg_we = 1'b0;
  endtask

  task automatic random_item(input logic [MIDI_W-1:0] hot, input logic [CHAN_W-1:0] filter);
    int                r;
    action_t           act;
    logic [MIDI_W-1:0] num;
    logic [MIDI_W-1:0] val;
    logic [CHAN_W-1:0] ch;
    logic [KNOB_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 60) act = ACT_CC;
    else if (r < 68) act = ACT_LEARN;
    else if (r < 82) act = ACT_SET;
    else act = ACT_ARM;
    num = ($urandom_range(0, 3) != 0) ? hot : MIDI_W'($urandom_range(0, 127));
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0: val = '0;
        1: val = 7'd64;
        default: val = MIDI_MAX;
      endcase
    end else begin
      val = MIDI_W'($urandom_range(0, 127));
    end
    if (filter != '0 && $urandom_range(0, 4) != 0) ch = filter;
    else ch = CHAN_W'($urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: pos = KNOB_W'(val) << FRACTION_BITS;
      3: pos = KNOB_W'($urandom_range(KNOB_MAX - 100, 2**KNOB_W - 1));
      default: pos = KNOB_W'($urandom_range(0, 2**KNOB_W - 1));
    endcase
    send_item(act, num, val, ch, pos);
  endtask

  initial begin
    logic [CHAN_W-1:0] filter;
    logic [MIDI_W-1:0] ctrl;
    logic              enable;
    logic [MIDI_W-1:0] hot;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(ACT_CC, 7'd5, MIDI_MAX, 5'd0, '0);
    send_item(ACT_SET, '0, '0, '0, '1);
    send_item(ACT_SET, '0, '0, '0, '0);
    send_item(ACT_ARM, '0, '0, '0, '0);
    send_item(ACT_LEARN, '0, '0, '0, '0);
    send_item(ACT_CC, 7'd0, 7'd33, 5'd31, '0);
    send_item(ACT_LEARN, '0, '0, '0, '0);
    send_item(ACT_CC, MIDI_MAX, 7'd64, 5'd16, '0);
    send_item(ACT_CC, MIDI_MAX, 7'd100, 5'd3, '0);
    send_item(ACT_CC, MIDI_MAX, 7'd10, 5'd0, '0);
    send_item(ACT_LEARN, '0, '0, '0, '0);
    send_item(ACT_LEARN, '0, '0, '0, '0);
    send_item(ACT_ARM, '0, '0, '0, '0);
    send_item(ACT_CC, MIDI_MAX, 7'd10, 5'd0, '0);
    send_item(ACT_ARM, '0, '0, '0, '0);
    send_item(ACT_CC, MIDI_MAX, 7'd0, 5'd0, '0);
    send_item(ACT_CC, MIDI_MAX, MIDI_MAX, 5'd0, '0);
    send_item(ACT_CC, 7'd126, 7'd50, 5'd0, '0);
    send_item(ACT_SET, '0, '0, '0, KNOB_MAX);
    send_item(ACT_SET, '0, '0, '0, KNOB_W'(KNOB_MAX + 1));
    drain();

    configure(5'd31, MIDI_MAX, 1'b0);
    write_reg(CFG_SPARE, '1);
    cfg_we = 1'b0;
    send_item(ACT_CC, MIDI_MAX, MIDI_MAX, 5'd31, '0);
    send_item(ACT_CC, MIDI_MAX, 7'd1, 5'd16, '0);
    send_item(ACT_ARM, '0, '0, '0, '0);
    send_item(ACT_LEARN, '0, '0, '0, '0);
    send_item(ACT_CC, 7'd1, 7'd90, 5'd0, '0);
    drain();

    configure(5'd16, '0, 1'b1);
    send_item(ACT_CC, 7'd0, 7'd5, 5'd16, '0);
    send_item(ACT_ARM, '0, '0, '0, '0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: begin filter = '0; ctrl = MIDI_MAX; enable = 1'b1; end
        1: begin filter = 5'd16; ctrl = 7'd1; enable = 1'b0; end
        2: begin filter = 5'd31; ctrl = '0; enable = 1'b1; end
        default: begin
          filter = ($urandom_range(0, 1) == 0) ? '0 : CHAN_W'($urandom_range(1, 16));
          ctrl = MIDI_W'($urandom_range(0, 127));
          enable = $urandom_range(0, 3) != 0;
        end
      endcase
      configure(filter, ctrl, enable);
      hot = (ctrl != '0) ? ctrl : MIDI_W'($urandom_range(1, 127));
      if (p == 1) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) random_item(hot, filter);
    end

    drain();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("midi_cc_learn_pickup_unit: match");
    end else begin
      $display("midi_cc_learn_pickup_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mccl_pkg.sv
rtl/mccl_in_stage.sv
rtl/mccl_core.sv
rtl/mccl_out_stage.sv
rtl/midi_cc_learn_pickup_unit.sv
sim/midi_cc_learn_pickup_checker.sv
sim/tb_midi_cc_learn_pickup_unit.sv
